// File: design/isms_pkg.sv
// ----------------------------------------------------------------------------
// Integer stack machine package
// Shared widths, status codes, opcodes, command classes and the decoder.
// ----------------------------------------------------------------------------
package isms_pkg;

    localparam int STACK_DEPTH_DEF = 256;
    localparam int DATA_W          = 32;
    localparam int OPC_W           = 5;
    localparam int DEPTH_W         = 9;
    localparam int PC_W            = 17;
    localparam int LEN_W           = 16;
    localparam int QUEUE_DEPTH     = 2;
    localparam logic [LEN_W-1:0] LEN_RESET = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_RET     = 3'd1,
        ST_JUMP    = 3'd2,
        ST_UNKNOWN = 3'd3,
        ST_UNDER   = 3'd4,
        ST_OVER    = 3'd5,
        ST_DIVZ    = 3'd6
    } status_t;

    localparam logic [OPC_W-1:0] OP_NOP  = 5'd0;
    localparam logic [OPC_W-1:0] OP_PUSH = 5'd1;
    localparam logic [OPC_W-1:0] OP_POP  = 5'd2;
    localparam logic [OPC_W-1:0] OP_RET  = 5'd3;
    localparam logic [OPC_W-1:0] OP_JNE  = 5'd4;
    localparam logic [OPC_W-1:0] OP_JMP  = 5'd5;
    localparam logic [OPC_W-1:0] OP_CMP  = 5'd6;
    localparam logic [OPC_W-1:0] OP_ADD  = 5'd7;
    localparam logic [OPC_W-1:0] OP_SUB  = 5'd8;
    localparam logic [OPC_W-1:0] OP_MUL  = 5'd9;
    localparam logic [OPC_W-1:0] OP_DIV  = 5'd10;
    localparam logic [OPC_W-1:0] OP_MOD  = 5'd11;
    localparam logic [OPC_W-1:0] OP_AND  = 5'd12;
    localparam logic [OPC_W-1:0] OP_OR   = 5'd13;
    localparam logic [OPC_W-1:0] OP_XOR  = 5'd14;
    localparam logic [OPC_W-1:0] OP_INV  = 5'd15;
    localparam logic [OPC_W-1:0] OP_NOT  = 5'd16;
    localparam logic [OPC_W-1:0] OP_EQ   = 5'd17;
    localparam logic [OPC_W-1:0] OP_NEQ  = 5'd18;
    localparam logic [OPC_W-1:0] OP_LAND = 5'd19;
    localparam logic [OPC_W-1:0] OP_LOR  = 5'd20;
    localparam logic [OPC_W-1:0] OP_LEQ  = 5'd21;
    localparam logic [OPC_W-1:0] OP_GEQ  = 5'd22;
    localparam logic [OPC_W-1:0] OP_GT   = 5'd23;
    localparam logic [OPC_W-1:0] OP_LT   = 5'd24;

    typedef enum logic [3:0] {
        K_NOP,
        K_PUSH,
        K_POP,
        K_RET,
        K_JNE,
        K_JMP,
        K_CMP,
        K_UNARY,
        K_BINARY,
        K_UNKNOWN
    } kind_t;

    typedef struct packed {
        kind_t                    kind;
        logic [OPC_W-1:0]         opcode;
        logic signed [DATA_W-1:0] operand;
    } cmd_t;

    function automatic kind_t classify(input logic [OPC_W-1:0] op);
        kind_t k;
        unique case (op) inside
            OP_NOP:              k = K_NOP;
            OP_PUSH:             k = K_PUSH;
            OP_POP:              k = K_POP;
            OP_RET:              k = K_RET;
            OP_JNE:              k = K_JNE;
            OP_JMP:              k = K_JMP;
            OP_CMP:              k = K_CMP;
            OP_INV, OP_NOT:      k = K_UNARY;
            [OP_ADD:OP_XOR]:     k = K_BINARY;
            [OP_EQ:OP_LT]:       k = K_BINARY;
            default:             k = K_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage

// File: design/isms_if.sv
// ----------------------------------------------------------------------------
// Integer stack machine channels
// Instruction, result and configuration write channels.
// ----------------------------------------------------------------------------
interface isms_in_if import isms_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [OPC_W-1:0]         opcode;
    logic signed [DATA_W-1:0] operand;

    modport source (output valid, output opcode, output operand, input ready);
    modport sink   (input valid, input opcode, input operand, output ready);
endinterface

interface isms_out_if import isms_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [2:0]               status;
    logic signed [DATA_W-1:0] top_value;
    logic [DEPTH_W-1:0]       stack_depth;
    logic [PC_W-1:0]          next_pc;
    logic                     flag_out;

    modport source (output valid, output status, output top_value, output stack_depth,
                    output next_pc, output flag_out, input ready);
    modport sink   (input valid, input status, input top_value, input stack_depth,
                    input next_pc, input flag_out, output ready);
endinterface

interface isms_cfg_if import isms_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/integer_stack_machine_step.sv
// ----------------------------------------------------------------------------
// Integer stack machine step
// One instruction per instruction transaction, one result transaction each.
//
//   channel  role    payload
//   instr    sink    opcode, operand
//   result   source  status, top_value, stack_depth, next_pc, flag_out
//   cfg      sink    data (program_length)
//
// Simple instructions finish from idle; pop to a nonempty stack and binary
// operations pass a read state (registered stack memory read); div and mod
// then use a 32-step iterative divider. A 2-entry queue decouples the front.
// Reset clears pointer, flag and pc at once; the stack memory needs no sweep.
// A stalled result holds in the output register while the queue keeps filling.
// ----------------------------------------------------------------------------
module integer_stack_machine_step import isms_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    isms_in_if.sink    instr,
    isms_out_if.source result,
    isms_cfg_if.sink   cfg
);

    logic             f_valid;
    logic             f_ready;
    cmd_t             f_cmd;
    logic             q_valid;
    logic             q_ready;
    cmd_t             q_cmd;
    logic [LEN_W-1:0] len_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= LEN_RESET;
        end
        else if (cfg.valid)
        begin
            len_reg <= cfg.data;
        end
    end

    isms_front u_front (
        .instr     (instr),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd       (f_cmd)
    );

    isms_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_cmd    (f_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    isms_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (q_valid),
        .cmd_ready      (q_ready),
        .cmd            (q_cmd),
        .program_length (len_reg),
        .result         (result)
    );

    a_err_pc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.status != ST_OK) |-> (result.next_pc == '0))
        else $error("error result with nonzero next_pc");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> ({23'b0, result.stack_depth} <= 32'(STACK_DEPTH)))
        else $error("stack depth above capacity");

    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.stack_depth == '0) |-> (result.top_value == '0))
        else $error("empty stack with nonzero top");

endmodule

// File: design/isms_front.sv
// ----------------------------------------------------------------------------
// Integer stack machine front end
// Accept instruction transactions and classify them into commands.
// ----------------------------------------------------------------------------
module isms_front import isms_pkg::*; (
    isms_in_if.sink instr,
    output logic    cmd_valid,
    input  logic    cmd_ready,
    output cmd_t    cmd
);

    assign cmd_valid   = instr.valid;
    assign instr.ready = cmd_ready;

    always_comb
    begin
        cmd.kind    = classify(instr.opcode);
        cmd.opcode  = instr.opcode;
        cmd.operand = instr.operand;
    end

endmodule

// File: design/isms_queue.sv
// ----------------------------------------------------------------------------
// Integer stack machine command queue
// Short FIFO between front end and execution back end.
// ----------------------------------------------------------------------------
module isms_queue import isms_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_cmd
);

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QCW-1:0]   count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != QCW'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: design/isms_div.sv
// ----------------------------------------------------------------------------
// Integer stack machine divider
// Signed 32-bit radix-2 restoring divider, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module isms_div import isms_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [DATA_W-1:0] dividend,
    input  logic signed [DATA_W-1:0] divisor,
    output logic                     done,
    output logic [DATA_W-1:0]        quotient,
    output logic [DATA_W-1:0]        remainder
);

    localparam int CNT_W = $clog2(DATA_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] den_reg;
    logic              negq_reg;
    logic              negr_reg;
    logic [DATA_W-1:0] mag_a;
    logic [DATA_W-1:0] mag_b;
    logic [DATA_W:0]   trial;

    assign mag_a = dividend[DATA_W-1] ? -dividend : dividend;
    assign mag_b = divisor[DATA_W-1]  ? -divisor  : divisor;
    assign trial = {rem_reg, quo_reg[DATA_W-1]} - {1'b0, den_reg};

    assign done      = done_reg;
    assign quotient  = negq_reg ? -quo_reg : quo_reg;
    assign remainder = negr_reg ? -rem_reg : rem_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg  <= mag_a;
            rem_reg  <= '0;
            den_reg  <= mag_b;
            negq_reg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
            negr_reg <= dividend[DATA_W-1];
        end
        else if (busy_reg)
        begin
            if (!trial[DATA_W])
            begin
                rem_reg <= trial[DATA_W-1:0];
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[DATA_W-2:0], quo_reg[DATA_W-1]};
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DATA_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

endmodule

// File: design/isms_back.sv
// ----------------------------------------------------------------------------
// Integer stack machine back end
// Execute commands against the stack memory and drive result transactions.
// ----------------------------------------------------------------------------
module isms_back import isms_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  cmd_t              cmd,
    input  logic [LEN_W-1:0]  program_length,
    isms_out_if.source        result
);

    localparam int AW   = $clog2(STACK_DEPTH);
    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int TW   = DATA_W + 2;

    typedef enum logic [1:0] {S_IDLE, S_READ, S_DIV} state_t;

    state_t             state_reg,  state_next;
    logic [SP_W-1:0]    sp_reg,     sp_next;
    logic               flag_reg,   flag_next;
    logic [PC_W-1:0]    pc_reg,     pc_next;
    logic [DATA_W-1:0]  top_reg,    top_next;
    cmd_t               cmdr_reg,   cmdr_next;
    logic [SP_W-1:0]    newsp_reg,  newsp_next;
    logic               ov_reg,     ov_next;
    status_t            ostat_reg,  ostat_next;
    logic [DATA_W-1:0]  otop_reg,   otop_next;
    logic [DEPTH_W-1:0] odepth_reg, odepth_next;
    logic [PC_W-1:0]    opc_reg,    opc_next;
    logic               oflag_reg,  oflag_next;

    logic [DATA_W-1:0]  mem [STACK_DEPTH];
    logic [DATA_W-1:0]  rd_reg;
    logic               we;
    logic [AW-1:0]      waddr;
    logic [DATA_W-1:0]  wdata;
    logic               re;
    logic [AW-1:0]      raddr;

    logic               div_start;
    logic               div_done;
    logic [DATA_W-1:0]  div_quo;
    logic [DATA_W-1:0]  div_rem;

    logic               out_free;
    logic               fin;
    logic               jump_ok;
    status_t            st;
    logic [SP_W-1:0]    sp_m1;
    logic [SP_W-1:0]    sp_m2;
    logic [SP_W-1:0]    pop_sp;
    logic [SP_W-1:0]    pop_m1;
    logic [TW-1:0]      target;
    logic               tgt_bad;
    logic [PC_W-1:0]    tgt_pc;
    logic [DATA_W-1:0]  alu_r;

    function automatic logic [DATA_W-1:0] alu(input logic [OPC_W-1:0] op,
                                              input logic signed [DATA_W-1:0] a,
                                              input logic signed [DATA_W-1:0] b);
        logic [2*DATA_W-1:0] prod;
        logic [DATA_W-1:0]   r;
        prod = $unsigned(a) * $unsigned(b);
        case (op)
            OP_ADD:  r = a + b;
            OP_SUB:  r = a - b;
            OP_MUL:  r = prod[DATA_W-1:0];
            OP_AND:  r = a & b;
            OP_OR:   r = a | b;
            OP_XOR:  r = a ^ b;
            OP_EQ:   r = DATA_W'(a == b);
            OP_NEQ:  r = DATA_W'(a != b);
            OP_LAND: r = DATA_W'((a != 0) && (b != 0));
            OP_LOR:  r = DATA_W'((a != 0) || (b != 0));
            OP_LEQ:  r = DATA_W'(a <= b);
            OP_GEQ:  r = DATA_W'(a >= b);
            OP_GT:   r = DATA_W'(a > b);
            default: r = DATA_W'(a < b);
        endcase
        return r;
    endfunction

    isms_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (rd_reg),
        .divisor   (top_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign sp_m1    = sp_reg - 1'b1;
    assign sp_m2    = sp_reg - SP_W'(2);
    assign pop_sp   = sp_reg - cmd.operand[SP_W-1:0];
    assign pop_m1   = pop_sp - 1'b1;
    assign target   = {{(TW-PC_W){1'b0}}, pc_reg} + {{(TW-DATA_W){cmd.operand[DATA_W-1]}},
                      cmd.operand};
    assign tgt_bad  = target[TW-1] ||
                      (target[TW-2:0] > {{(TW-1-LEN_W){1'b0}}, program_length});
    assign tgt_pc   = target[PC_W-1:0] + 1'b1;
    assign alu_r    = alu(cmdr_reg.opcode, rd_reg, top_reg);
    assign out_free = !ov_reg || result.ready;

    assign result.valid       = ov_reg;
    assign result.status      = ostat_reg;
    assign result.top_value   = otop_reg;
    assign result.stack_depth = odepth_reg;
    assign result.next_pc     = opc_reg;
    assign result.flag_out    = oflag_reg;

    always_comb
    begin
        state_next  = state_reg;
        sp_next     = sp_reg;
        flag_next   = flag_reg;
        pc_next     = pc_reg;
        top_next    = top_reg;
        cmdr_next   = cmdr_reg;
        newsp_next  = newsp_reg;
        ov_next     = ov_reg && !result.ready;
        ostat_next  = ostat_reg;
        otop_next   = otop_reg;
        odepth_next = odepth_reg;
        opc_next    = opc_reg;
        oflag_next  = oflag_reg;
        we          = 1'b0;
        waddr       = '0;
        wdata       = '0;
        re          = 1'b0;
        raddr       = '0;
        div_start   = 1'b0;
        cmd_ready   = 1'b0;
        fin         = 1'b0;
        jump_ok     = 1'b0;
        st          = ST_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_ready = 1'b1;
                    cmdr_next = cmd;
                    fin       = 1'b1;
                    case (cmd.kind)
                        K_NOP:
                        begin
                        end
                        K_PUSH:
                        begin
                            if (sp_reg == SP_W'(STACK_DEPTH))
                            begin
                                st = ST_OVER;
                            end
                            else
                            begin
                                we       = 1'b1;
                                waddr    = sp_reg[AW-1:0];
                                wdata    = cmd.operand;
                                sp_next  = sp_reg + 1'b1;
                                top_next = cmd.operand;
                            end
                        end
                        K_POP:
                        begin
                            if (!cmd.operand[DATA_W-1] && (cmd.operand != '0))
                            begin
                                if (cmd.operand > {{(DATA_W-SP_W){1'b0}}, sp_reg})
                                begin
                                    st = ST_UNDER;
                                end
                                else if (pop_sp == '0)
                                begin
                                    sp_next  = '0;
                                    top_next = '0;
                                end
                                else
                                begin
                                    fin        = 1'b0;
                                    re         = 1'b1;
                                    raddr      = pop_m1[AW-1:0];
                                    newsp_next = pop_sp;
                                    state_next = S_READ;
                                end
                            end
                        end
                        K_RET:
                        begin
                            st = ST_RET;
                        end
                        K_JNE:
                        begin
                            if (flag_reg)
                            begin
                                flag_next = 1'b0;
                            end
                            else if (tgt_bad)
                            begin
                                st = ST_JUMP;
                            end
                            else
                            begin
                                jump_ok = 1'b1;
                            end
                        end
                        K_JMP:
                        begin
                            if (tgt_bad)
                            begin
                                st = ST_JUMP;
                            end
                            else
                            begin
                                jump_ok = 1'b1;
                            end
                        end
                        K_CMP:
                        begin
                            if (sp_reg == '0)
                            begin
                                st = ST_UNDER;
                            end
                            else
                            begin
                                flag_next = (top_reg != '0);
                            end
                        end
                        K_UNARY:
                        begin
                            if (sp_reg == '0)
                            begin
                                st = ST_UNDER;
                            end
                            else
                            begin
                                we       = 1'b1;
                                waddr    = sp_m1[AW-1:0];
                                wdata    = (cmd.opcode == OP_INV) ? ~top_reg
                                                                  : DATA_W'(top_reg == '0);
                                top_next = wdata;
                            end
                        end
                        K_BINARY:
                        begin
                            if (sp_reg < SP_W'(2))
                            begin
                                st = ST_UNDER;
                            end
                            else
                            begin
                                fin        = 1'b0;
                                re         = 1'b1;
                                raddr      = sp_m2[AW-1:0];
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            st = ST_UNKNOWN;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                if (cmdr_reg.kind == K_POP)
                begin
                    fin        = 1'b1;
                    sp_next    = newsp_reg;
                    top_next   = rd_reg;
                    state_next = S_IDLE;
                end
                else if ((cmdr_reg.opcode == OP_DIV) || (cmdr_reg.opcode == OP_MOD))
                begin
                    if (top_reg == '0)
                    begin
                        fin        = 1'b1;
                        st         = ST_DIVZ;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
                else
                begin
                    fin        = 1'b1;
                    we         = 1'b1;
                    waddr      = sp_m2[AW-1:0];
                    wdata      = alu_r;
                    sp_next    = sp_m1;
                    top_next   = alu_r;
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    fin        = 1'b1;
                    we         = 1'b1;
                    waddr      = sp_m2[AW-1:0];
                    wdata      = (cmdr_reg.opcode == OP_DIV) ? div_quo : div_rem;
                    sp_next    = sp_m1;
                    top_next   = wdata;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            if (st != ST_OK)
            begin
                pc_next = '0;
            end
            else if (jump_ok)
            begin
                pc_next = tgt_pc;
            end
            else
            begin
                pc_next = pc_reg + 1'b1;
            end
            ov_next     = 1'b1;
            ostat_next  = st;
            otop_next   = top_next;
            odepth_next = DEPTH_W'(sp_next);
            opc_next    = pc_next;
            oflag_next  = flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sp_reg    <= '0;
            flag_reg  <= 1'b0;
            pc_reg    <= '0;
            top_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            flag_reg  <= flag_next;
            pc_reg    <= pc_next;
            top_reg   <= top_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmdr_reg   <= cmdr_next;
        newsp_reg  <= newsp_next;
        ostat_reg  <= ostat_next;
        otop_reg   <= otop_next;
        odepth_reg <= odepth_next;
        opc_reg    <= opc_next;
        oflag_reg  <= oflag_next;
    end

endmodule

// File: bench/isms_checker.sv
// ----------------------------------------------------------------------------
// Stack machine step checker
// Watches the instruction, result and configuration channels, keeps its own
// copy of the machine state, predicts each result and compares it field by
// field.
// ----------------------------------------------------------------------------
module isms_checker import isms_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    isms_in_if.sink    instr,
    isms_out_if.sink   result,
    isms_cfg_if.sink   cfg,
    output int         errors,
    output int         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]        status;
        logic [DATA_W-1:0] top;
        logic [DEPTH_W-1:0] depth;
        logic [PC_W-1:0]   pc;
        logic              flag;
    } step_res_t;

    logic [DATA_W-1:0]  mstack [STACK_DEPTH_DEF];
    logic [DEPTH_W-1:0] msp;
    logic               mflag;
    logic [PC_W-1:0]    mpc;
    logic [LEN_W-1:0]   mlen;
    step_res_t          expected_q [$];

    assign pending = expected_q.size();

    function automatic step_res_t execute(input logic [OPC_W-1:0] op,
                                          input logic [DATA_W-1:0] opnd);
        step_res_t         r;
        logic [2:0]        st;
        logic [PC_W-1:0]   nxt;
        logic              jump;
        logic signed [DATA_W-1:0] a, b;
        logic [DATA_W-1:0] v;
        longint            tgt;
        st   = ST_OK;
        nxt  = mpc + 1'b1;
        jump = 1'b0;
        v    = '0;
        case (classify(op))
            K_NOP: ;
            K_PUSH:
                if (msp >= STACK_DEPTH_DEF) st = ST_OVER;
                else
                begin
                    mstack[msp] = opnd;
                    msp = msp + 1'b1;
                end
            K_POP:
                if ($signed(opnd) > 0)
                begin
                    if ($signed(opnd) > longint'(msp)) st = ST_UNDER;
                    else msp = msp - opnd[DEPTH_W-1:0];
                end
            K_RET: st = ST_RET;
            K_JNE:
                if (mflag) mflag = 1'b0;
                else jump = 1'b1;
            K_JMP: jump = 1'b1;
            K_CMP:
                if (msp == 0) st = ST_UNDER;
                else mflag = (mstack[msp-1] != 0);
            K_UNARY:
                if (msp == 0) st = ST_UNDER;
                else if (op == OP_INV) mstack[msp-1] = ~mstack[msp-1];
                else mstack[msp-1] = (mstack[msp-1] == 0);
            K_BINARY:
                if (msp < 2) st = ST_UNDER;
                else
                begin
                    a = mstack[msp-2];
                    b = mstack[msp-1];
                    case (op)
                        OP_ADD:  v = a + b;
                        OP_SUB:  v = a - b;
                        OP_MUL:  v = a * b;
                        OP_DIV, OP_MOD:
                            if (b == 0) st = ST_DIVZ;
                            else if (a == 32'sh80000000 && b == -1)
                                v = (op == OP_DIV) ? a : '0;
                            else v = (op == OP_DIV) ? a / b : a % b;
                        OP_AND:  v = a & b;
                        OP_OR:   v = a | b;
                        OP_XOR:  v = a ^ b;
                        OP_EQ:   v = (a == b);
                        OP_NEQ:  v = (a != b);
                        OP_LAND: v = (a != 0 && b != 0);
                        OP_LOR:  v = (a != 0 || b != 0);
                        OP_LEQ:  v = (a <= b);
                        OP_GEQ:  v = (a >= b);
                        OP_GT:   v = (a > b);
                        default: v = (a < b);
                    endcase
                    if (st == ST_OK)
                    begin
                        msp = msp - 1'b1;
                        mstack[msp-1] = v;
                    end
                end
            default: st = ST_UNKNOWN;
        endcase
        if (jump)
        begin
            tgt = longint'(mpc) + longint'($signed(opnd));
            if (tgt < 0 || tgt > longint'(mlen)) st = ST_JUMP;
            else nxt = PC_W'(tgt + 1);
        end
        if (st != ST_OK) nxt = '0;
        mpc = nxt;
        r.status = st;
        r.top    = (msp != 0) ? mstack[msp-1] : '0;
        r.depth  = msp;
        r.pc     = mpc;
        r.flag   = mflag;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        step_res_t got, want;
        if (!rst_n)
        begin
            msp    = '0;
            mflag  = 1'b0;
            mpc    = '0;
            mlen   = LEN_RESET;
            errors <= 0;
            expected_q.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready) mlen = cfg.data;
            if (instr.valid && instr.ready)
                expected_q.push_back(execute(instr.opcode, instr.operand));
            if (result.valid && result.ready)
            begin
                got = {result.status, result.top_value, result.stack_depth,
                       result.next_pc, result.flag_out};
                if (expected_q.size() == 0)
                begin
                    if (errors < 10) $display("unexpected result %h", got);
                    errors <= errors + 1;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got !== want)
                    begin
                        if (errors < 10)
                            $display({"mismatch: exp st=%0d top=%h d=%0d pc=%0d f=%b,",
                                      " got st=%0d top=%h d=%0d pc=%0d f=%b"},
                                want.status, want.top, want.depth, want.pc, want.flag,
                                got.status, got.top, got.depth, got.pc, got.flag);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// Stack machine step testbench
// Drives directed and random instruction streams with random gaps and
// back-pressure, rewrites the program length between phases, and reports the
// checker's verdict.
// ----------------------------------------------------------------------------
module tb;
    import isms_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   errors, pending;
    int   depth_est;
    bit   hold_off = 1'b0;

    isms_in_if  instr ();
    isms_out_if result ();
    isms_cfg_if cfg ();

    integer_stack_machine_step u_dut (.clk(clk), .rst_n(rst_n), .instr(instr),
                                      .result(result), .cfg(cfg));
    isms_checker u_chk (.clk(clk), .rst_n(rst_n), .instr(instr), .result(result),
                        .cfg(cfg), .errors(errors), .pending(pending));

    always #2 clk = ~clk;

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send(input logic [OPC_W-1:0] op, input logic [DATA_W-1:0] v);
        instr.valid   <= 1'b1;
        instr.opcode  <= op;
        instr.operand <= v;
        @(posedge clk);
        while (!instr.ready) @(posedge clk);
        if (op == OP_PUSH && depth_est < 256) depth_est++;
    endtask

    task automatic idle_gap();
        int g;
        g = gap_len();
        if (g > 0)
        begin
            instr.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic drain();
        instr.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_len(input logic [LEN_W-1:0] v);
        cfg.valid <= 1'b1;
        cfg.data  <= v;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        cfg.valid <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] rand_val();
        case ($urandom_range(0, 5))
            0: return 32'h80000000;
            1: return 32'h7FFFFFFF;
            2: return $urandom_range(0, 1) ? 32'hFFFFFFFF : 32'h0;
            3: return $urandom_range(0, 9);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_item();
        int p;
        logic [OPC_W-1:0] op;
        logic [DATA_W-1:0] v;
        p = $urandom_range(0, 99);
        v = rand_val();
        if (p < 30) op = OP_PUSH;
        else if (p < 60) op = OPC_W'(OP_ADD + $urandom_range(0, 17));
        else if (p < 67) op = OP_CMP;
        else if (p < 77)
        begin
            op = $urandom_range(0, 1) ? OP_JNE : OP_JMP;
            v = $urandom_range(0, 3) ? DATA_W'($signed($urandom_range(0, 40)) - 20) : $urandom;
        end
        else if (p < 85)
        begin
            op = OP_POP;
            v = $urandom_range(0, 5) ? DATA_W'($urandom_range(0, 3)) : $urandom;
        end
        else if (p < 90) op = OP_NOP;
        else if (p < 93) op = OP_RET;
        else op = OPC_W'($urandom);
        if (op == OP_POP && $signed(v) > 0 && $signed(v) <= depth_est) depth_est -= int'(v);
        send(op, v);
        idle_gap();
    endtask

    initial
    begin
        instr.valid   <= 1'b0;
        instr.opcode  <= '0;
        instr.operand <= '0;
        cfg.valid     <= 1'b0;
        cfg.data      <= '0;
        depth_est     = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(OP_ADD, 0);
        send(OP_INV, 0);
        send(OP_CMP, 0);
        send(OP_POP, 1);
        send(OP_PUSH, 32'h80000000);
        send(OP_PUSH, 32'hFFFFFFFF);
        send(OP_DIV, 0);
        send(OP_PUSH, 32'hFFFFFFFF);
        send(OP_MOD, 0);
        send(OP_PUSH, 0);
        send(OP_DIV, 0);
        send(OP_PUSH, 32'h7FFFFFFF);
        send(OP_CMP, 0);
        send(OP_JNE, 5);
        send(OP_JNE, 5);
        send(OP_JMP, 32'h80000000);
        send(OP_JMP, 32'h7FFFFFFF);
        send(OP_NOT, 0);
        send(OP_INV, 0);
        send(OP_POP, 32'hFFFFFFFF);
        send(OP_POP, 200);
        send(5'd25, 0);
        send(5'd31, 0);
        send(OP_RET, 0);
        drain();

        write_len(16'd0);
        send(OP_JMP, 0);
        send(OP_JMP, 1);
        repeat (300) random_item();
        drain();

        write_len(16'd40);
        for (int i = 0; i < 260; i++) send(OP_PUSH, $urandom);
        send(OP_MUL, 0);
        depth_est = 255;
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(posedge clk);
                hold_off = 1'b0;
            end
            repeat (300) random_item();
        join
        drain();

        write_len(16'd65535);
        send(OP_POP, 32'd256);
        depth_est = 0;
        repeat (200) random_item();
        drain();

        write_len(16'd12);
        repeat (250) random_item();
        drain();

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        result.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off) result.ready <= 1'b0;
            else if ($urandom_range(0, 3) == 0) result.ready <= ~result.ready;
            else result.ready <= 1'b1;
        end
    end

    initial
    begin
        #4ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
